[rtl/wlnr_pkg.sv]
// Shared types, constants and combine functions for the wired-logic net resolver.
package wlnr_pkg;

    localparam int NET_WIDTH   = 8;
    localparam int VAL_W       = 2 * NET_WIDTH;
    localparam int NUM_DRIVERS = 16;
    localparam int PORT_W      = 4;
    localparam int GROUP       = 4;
    localparam int NUM_ROWS    = 6;
    localparam int ROW_W       = 3;
    localparam int LVL_W       = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CODE_0 = 2'd0;
    localparam logic [1:0] CODE_1 = 2'd1;
    localparam logic [1:0] CODE_Z = 2'd2;
    localparam logic [1:0] CODE_X = 2'd3;

    // Tree levels: 16 leaves, 4 branch nodes, 1 root.
    localparam logic [LVL_W-1:0] LVL_LEAF = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_ROOT = 2'd2;

    // First row of each level; one row holds a group of four nodes.
    localparam logic [ROW_W-1:0] ROW_BASE_LEAF = 3'd0;
    localparam logic [ROW_W-1:0] ROW_BASE_MID  = 3'd4;
    localparam logic [ROW_W-1:0] ROW_BASE_ROOT = 3'd5;

    typedef struct packed {
        logic             driven;
        logic [VAL_W-1:0] bits;
    } node_t;

    typedef node_t [GROUP-1:0] row_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        node_t             node;
    } item_t;

    typedef struct packed {
        logic             undriven;
        logic [VAL_W-1:0] value;
    } result_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_WALK,
        TS_EMIT
    } tree_state_t;

    function automatic logic [ROW_W-1:0] row_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [PORT_W-1:0] p);
        logic [ROW_W-1:0] base;
        case (lvl)
            LVL_LEAF: base = ROW_BASE_LEAF;
            LVL_MID:  base = ROW_BASE_MID;
            default:  base = ROW_BASE_ROOT;
        endcase
        return base + ROW_W'(p >> 2);
    endfunction

    // Per-bit wired combine; Z is the identity, dominant code wins, then X.
    function automatic logic [VAL_W-1:0] combine_bits(input logic [VAL_W-1:0] a,
                                                      input logic [VAL_W-1:0] b,
                                                      input logic mode);
        logic [1:0]       dom;
        logic [1:0]       recessive;
        logic [1:0]       ab;
        logic [1:0]       bb;
        logic [1:0]       r;
        logic [VAL_W-1:0] res;
        dom       = mode ? CODE_1 : CODE_0;
        recessive = mode ? CODE_0 : CODE_1;
        res       = '0;
        for (int i = 0; i < NET_WIDTH; i++) begin
            ab = a[2*i +: 2];
            bb = b[2*i +: 2];
            if (ab == CODE_Z) begin
                r = bb;
            end else if (bb == CODE_Z) begin
                r = ab;
            end else if (ab == dom || bb == dom) begin
                r = dom;
            end else if (ab == CODE_X || bb == CODE_X) begin
                r = CODE_X;
            end else begin
                r = recessive;
            end
            res[2*i +: 2] = r;
        end
        return res;
    endfunction

    function automatic node_t merge_node(input node_t acc, input node_t n, input logic mode);
        node_t res;
        if (!n.driven) begin
            res = acc;
        end else if (!acc.driven) begin
            res = n;
        end else begin
            res.driven = 1'b1;
            res.bits   = combine_bits(acc.bits, n.bits, mode);
        end
        return res;
    endfunction

    function automatic node_t reduce_row(input row_t row, input logic mode);
        node_t acc;
        acc = row[0];
        for (int i = 1; i < GROUP; i++) begin
            acc = merge_node(acc, row[i], mode);
        end
        return acc;
    endfunction

endpackage

[rtl/wlnr_front.sv]
// Input stage: takes items, drops out-of-range ports, builds the leaf node.
module wlnr_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,
    input  logic                    s_tuser,
    output logic                    push_valid,
    output wlnr_pkg::item_t         push_item,
    input  logic                    push_full
);

    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    wlnr_pkg::item_t       hold_item_reg;
    wlnr_pkg::item_t       item_next;
    logic                  accept;
    logic                  in_range;
    logic [wlnr_pkg::PORT_W-1:0] port;

    assign port     = s_tdata[wlnr_pkg::PORT_W-1:0];
    assign in_range = {1'b0, port} < (wlnr_pkg::PORT_W + 1)'(wlnr_pkg::NUM_DRIVERS);
    assign s_tready = !hold_valid_reg || !push_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        item_next.port        = port;
        item_next.node.driven = !s_tuser;
        item_next.node.bits   = s_tuser ? '0
                              : s_tdata[wlnr_pkg::PORT_W +: wlnr_pkg::VAL_W];
    end

    always_comb begin
        if (hold_valid_reg && push_full) begin
            hold_valid_next = 1'b1;
        end else begin
            hold_valid_next = accept && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_item_reg <= item_next;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

endmodule

[rtl/wlnr_fifo.sv]
// Two-entry item queue between the input stage and the tree engine.
module wlnr_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wlnr_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output wlnr_pkg::item_t pop_item
);

    localparam int PTR_W = $clog2(wlnr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wlnr_pkg::QUEUE_DEPTH + 1);

    wlnr_pkg::item_t   entry_reg [wlnr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == CNT_W'(wlnr_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(wlnr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(wlnr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/wlnr_tree.sv]
// Tree engine: walks the node store one level a cycle and updates partial results.
module wlnr_tree (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wired_mode,
    input  logic                q_valid,
    input  wlnr_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                res_valid,
    output wlnr_pkg::result_t   res,
    input  logic                res_ready
);

    wlnr_pkg::tree_state_t state_reg;
    wlnr_pkg::tree_state_t state_next;

    logic [wlnr_pkg::LVL_W-1:0]  lvl_reg;
    logic [wlnr_pkg::PORT_W-1:0] p_reg;
    wlnr_pkg::node_t             v_reg;
    wlnr_pkg::row_t              rd_row_reg;
    logic                        rd_valid_reg;
    logic [wlnr_pkg::NUM_ROWS-1:0] row_valid_reg;
    wlnr_pkg::row_t              mem [wlnr_pkg::NUM_ROWS];
    wlnr_pkg::result_t           res_reg;

    wlnr_pkg::row_t              cur_row;
    wlnr_pkg::row_t              new_row;
    wlnr_pkg::node_t             acc;
    logic                        same;
    logic                        last;
    logic                        rd_en;
    logic                        wr_en;
    logic [wlnr_pkg::ROW_W-1:0]  rd_addr;
    logic [wlnr_pkg::ROW_W-1:0]  wr_addr;

    // A row never written reads as four undriven nodes.
    always_comb begin
        cur_row = rd_valid_reg ? rd_row_reg : '0;
        new_row = cur_row;
        new_row[p_reg[1:0]] = v_reg;
    end

    assign same = cur_row[p_reg[1:0]] == v_reg;
    assign last = lvl_reg == wlnr_pkg::LVL_ROOT;
    assign acc  = wlnr_pkg::reduce_row(new_row, wired_mode);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wlnr_pkg::TS_IDLE: begin
                if (q_valid) begin
                    state_next = wlnr_pkg::TS_WALK;
                end
            end
            wlnr_pkg::TS_WALK: begin
                if (same) begin
                    state_next = wlnr_pkg::TS_IDLE;
                end else if (last) begin
                    state_next = wlnr_pkg::TS_EMIT;
                end
            end
            wlnr_pkg::TS_EMIT: begin
                if (res_ready) begin
                    state_next = wlnr_pkg::TS_IDLE;
                end
            end
            default: state_next = wlnr_pkg::TS_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        res_valid = 1'b0;
        rd_addr   = wlnr_pkg::row_addr(lvl_reg + wlnr_pkg::LVL_W'(1), p_reg >> 2);
        wr_addr   = wlnr_pkg::row_addr(lvl_reg, p_reg);
        case (state_reg)
            wlnr_pkg::TS_IDLE: begin
                q_pop   = q_valid;
                rd_en   = q_valid;
                rd_addr = wlnr_pkg::row_addr(wlnr_pkg::LVL_LEAF, q_item.port);
            end
            wlnr_pkg::TS_WALK: begin
                wr_en = !same;
                rd_en = !same && !last;
            end
            wlnr_pkg::TS_EMIT: begin
                res_valid = 1'b1;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wlnr_pkg::TS_IDLE;
            lvl_reg       <= wlnr_pkg::LVL_LEAF;
            row_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                lvl_reg <= wlnr_pkg::LVL_LEAF;
            end else if (wr_en && !last) begin
                lvl_reg <= lvl_reg + wlnr_pkg::LVL_W'(1);
            end
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            p_reg <= q_item.port;
            v_reg <= q_item.node;
        end else if (wr_en && !last) begin
            p_reg <= p_reg >> 2;
            v_reg <= acc;
        end
        if (wr_en && last) begin
            res_reg.undriven <= !v_reg.driven;
            res_reg.value    <= v_reg.driven ? v_reg.bits : '0;
        end
    end

    // Node store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= new_row;
        end
        if (rd_en) begin
            rd_row_reg   <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign res = res_reg;

endmodule

[rtl/wired_logic_net_resolver_unit.sv]
// Top level of the wired-logic (triand / trior) net resolver.
// An accepted item passes the front register and the queue, is popped with a
//   leaf read, takes one walk step per tree level (3 levels for 16 drivers)
//   and, if it changed the root, is handed off to the output register.
// The engine walks one item at a time; one that meets an unchanged node stops early.
// Reset: synchronous active-low aresetn clears control, the mode and the row
//   valid bits, so every tree node reads as undriven right after reset.
module wired_logic_net_resolver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: wired_mode (0 = wired AND, 1 = wired OR)
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] driver_port, [19:4] driver_value, rest zero
    input  logic        s_tuser,   // [0] driver_released
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] net_value
    output logic        m_tuser    // [0] net_undriven
);

    logic              wired_mode_reg;

    // front to queue
    logic              push_valid;
    wlnr_pkg::item_t   push_item;
    logic              q_full;

    // queue to tree engine
    logic              q_not_empty;
    wlnr_pkg::item_t   q_item;
    logic              q_pop;

    // tree engine to output register
    logic              res_valid;
    logic              res_ready;
    wlnr_pkg::result_t res;

    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic              m_tuser_reg;

    // Mode register; the user must change it only while the block is idle, as the
    // block does not enforce it; the engine then reads it directly during each combine.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wired_mode_reg <= 1'b0;
        end else if (cfg_wen) begin
            wired_mode_reg <= cfg_wdata;
        end
    end

    // Front: takes items, filters bad ports, forms the new leaf node.
    wlnr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (q_full)
    );

    // Short queue so the front keeps taking items while the tree walks.
    wlnr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    // Back: walks leaf -> branch -> root, stops early when a node is unchanged.
    wlnr_tree u_tree (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wired_mode (wired_mode_reg),
        .q_valid    (q_not_empty),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // Output register: the engine hands off a root change and moves on
    // while the item waits here for the sink.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= res.value;
            m_tuser_reg <= res.undriven;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/wlnr_checker.sv]
// Port-level checks for the wired-logic net resolver, bound to the top level.
module wlnr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An undriven net always reports an all-zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("undriven net with nonzero value");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The input side is open in the cycle after a reset cycle.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind wired_logic_net_resolver_unit wlnr_checker u_wlnr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/net_resolution_checker.sv]
`timescale 1ns / 100ps
// Checker for the wired-logic net resolver: mirrors the driver tree and compares every result.
module net_resolution_checker
    import wlnr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] driver_port, [19:4] driver_value, rest zero
    input  logic        s_tuser,   // [0] driver_released
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] net_value
    input  logic        m_tuser,   // [0] net_undriven
    output int          mismatch_count,
    output int          pending_results
);

    localparam int TREE_SIZE = 2 * NUM_DRIVERS + 2;

    node_t   net_tree [TREE_SIZE];
    logic    or_mode = 1'b0;
    result_t expected_nets [$];
    int      errors  = 0;
    int      waiting = 0;

    assign mismatch_count  = errors;
    assign pending_results = waiting;

    // one bit of the wired net: Z yields, equal codes stay, else dominant code or X
    function automatic logic [1:0] wire_pair(input logic [1:0] a, input logic [1:0] b,
                                             input logic use_or);
        logic [1:0] win_code;
        win_code = use_or ? CODE_1 : CODE_0;
        if (a == CODE_Z) return b;
        if (b == CODE_Z) return a;
        if (a == b) return a;
        if (a == win_code || b == win_code) return win_code;
        return CODE_X;
    endfunction

    function automatic node_t join_nodes(input node_t acc, input node_t n);
        node_t res;
        res = acc;
        if (n.driven && !acc.driven) begin
            res = n;
        end else if (n.driven) begin
            for (int b = 0; b < NET_WIDTH; b++) begin
                res.bits[2*b +: 2] = wire_pair(acc.bits[2*b +: 2], n.bits[2*b +: 2], or_mode);
            end
        end
        return res;
    endfunction

    // Applies one driver update; returns 1 with the new net when the root changes.
    function automatic logic update_driver(input logic [PORT_W-1:0] port,
                                           input logic [VAL_W-1:0] value,
                                           input logic dropped,
                                           output result_t net);
        node_t leaf;
        node_t acc;
        int    lvl_base;
        int    lvl_span;
        int    idx;
        int    up_base;
        int    first;
        int    stop;
        net         = '0;
        acc         = '0;
        leaf.driven = !dropped;
        leaf.bits   = dropped ? '0 : value;
        if (int'(port) >= NUM_DRIVERS) return 1'b0;
        if (net_tree[port] === leaf) return 1'b0;
        net_tree[port] = leaf;
        lvl_base = 0;
        lvl_span = NUM_DRIVERS;
        idx      = int'(port);
        while (lvl_span > 1) begin
            up_base = lvl_base + lvl_span;
            first   = lvl_base + (idx / GROUP) * GROUP;
            stop    = (first + GROUP < up_base) ? first + GROUP : up_base;
            acc     = net_tree[first];
            for (int k = first + 1; k < stop; k++) begin
                acc = join_nodes(acc, net_tree[k]);
            end
            if (net_tree[up_base + idx / GROUP] === acc) return 1'b0;
            net_tree[up_base + idx / GROUP] = acc;
            lvl_base = up_base;
            lvl_span = (lvl_span + GROUP - 1) / GROUP;
            idx      = idx / GROUP;
        end
        net.undriven = !acc.driven;
        net.value    = acc.driven ? acc.bits : '0;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        result_t net;
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TREE_SIZE; i++) begin
                net_tree[i] = '0;
            end
            or_mode = 1'b0;
            expected_nets.delete();
        end else begin
            if (cfg_wen) begin
                or_mode = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                if (update_driver(s_tdata[PORT_W-1:0], s_tdata[PORT_W +: VAL_W], s_tuser, net)) begin
                    expected_nets.push_back(net);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_nets.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual value %h undriven %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_nets.pop_front();
                    if (m_tdata !== want.value) begin
                        errors++;
                        $display("%0t: net_value mismatch: expected %h, actual %h",
                                 $time, want.value, m_tdata);
                    end
                    if (m_tuser !== want.undriven) begin
                        errors++;
                        $display("%0t: net_undriven mismatch: expected %b, actual %b",
                                 $time, want.undriven, m_tuser);
                    end
                end
            end
        end
        waiting <= expected_nets.size();
    end

endmodule

[test/tb_wired_logic_net_resolver_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the wired-logic net resolver: stimulus, handshake idling and verdict.
module tb_wired_logic_net_resolver_unit;
    import wlnr_pkg::*;

    // Generous cycle budget; a correct run needs a small fraction of it.
    localparam int RUN_LIMIT     = 300000;
    // Items that change nothing give no result, so wait this long after the last
    // result before touching the mode.
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 208;
    localparam int IDLE_PCT      = 38;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [3:0] driver_port, [19:4] driver_value, rest zero
    logic        s_tuser   = 1'b0; // [0] driver_released
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [15:0] net_value
    logic        m_tuser;          // [0] net_undriven

    int          cycle_count = 0;
    int          mismatch_count;
    int          pending_results;
    // when set, neither side idles: back-to-back items at full rate
    logic        calm = 1'b0;

    // what the testbench last drove on each port, to replay no-change items
    logic [VAL_W-1:0] drv_value [NUM_DRIVERS];
    logic             drv_on    [NUM_DRIVERS];

    wired_logic_net_resolver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    net_resolution_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop if the handshakes ever hang
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb_wired_logic_net_resolver_unit NOT OK");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offer one item, with random idle cycles in front, and hold it until taken.
    // s_tready is sampled at the falling edge, where nothing is changing.
    task automatic send_item(input logic [PORT_W-1:0] port, input logic [VAL_W-1:0] value,
                             input logic dropped);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, value, port};
        s_tuser  <= dropped;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        drv_on[port]    = !dropped;
        drv_value[port] = dropped ? '0 : value;
    endtask

    // Drop valid, let every expected result drain, then let the walk settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic or_sel);
        cfg_wen   <= 1'b1;
        cfg_wdata <= or_sel;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic release_all();
        for (int p = 0; p < NUM_DRIVERS; p++) begin
            send_item(PORT_W'(p), VAL_W'($urandom), 1'b1);
        end
    endtask

    // Random 4-state vector; several shapes so Z-heavy and uniform nets show up.
    function automatic logic [VAL_W-1:0] pick_drive_vector();
        logic [VAL_W-1:0] v;
        logic [1:0]       code;
        int               r;
        int               hot;
        v = '0;
        case ($urandom_range(0, 3))
            0: v = VAL_W'($urandom);
            1: begin
                for (int b = 0; b < NET_WIDTH; b++) begin
                    r = $urandom_range(0, 5);
                    v[2*b +: 2] = (r >= 3) ? CODE_Z : 2'(r);
                end
            end
            2: begin
                code = 2'($urandom_range(0, 3));
                v    = {NET_WIDTH{code}};
            end
            default: begin
                hot = $urandom_range(0, NET_WIDTH - 1);
                v   = {NET_WIDTH{CODE_Z}};
                v[2*hot +: 2] = 2'($urandom_range(0, 3));
            end
        endcase
        return v;
    endfunction

    initial begin : stimulus
        int                r;
        logic [PORT_W-1:0] port;
        for (int p = 0; p < NUM_DRIVERS; p++) begin
            drv_on[p]    = 1'b0;
            drv_value[p] = '0;
        end

        // single reset pulse
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, wired AND ---
        write_mode(1'b0);
        send_item(4'd0,  16'h5555, 1'b0);  // all ones
        send_item(4'd5,  16'hAAAA, 1'b0);  // all Z in another group: root unchanged
        send_item(4'd1,  16'hFFFF, 1'b0);  // X meets 1
        send_item(4'd15, 16'h0000, 1'b0);  // 0 dominates
        send_item(4'd15, 16'h0000, 1'b0);  // same value, nothing happens
        send_item(4'd2,  16'h1B1B, 1'b0);  // each of the four codes in every byte
        send_item(4'd15, 16'h1234, 1'b1);  // release, value ignored
        send_item(4'd15, 16'hFFFF, 1'b1);  // second release changes nothing
        send_item(4'd0,  16'h0000, 1'b1);
        send_item(4'd1,  16'h0000, 1'b1);
        send_item(4'd2,  16'h0000, 1'b1);
        send_item(4'd5,  16'h0000, 1'b1);  // last driver gone: net undriven
        send_item(4'd7,  16'h5555, 1'b1);  // release while undriven
        send_item(4'd8,  16'hE4E4, 1'b0);

        // --- directed, wired OR; the stored group of port 8 keeps its AND result ---
        wait_drained();
        write_mode(1'b1);
        send_item(4'd9,  16'h0000, 1'b0);
        send_item(4'd12, 16'h5555, 1'b0);  // 1 dominates
        send_item(4'd3,  16'hFFFF, 1'b0);
        send_item(4'd12, 16'h0000, 1'b1);
        send_item(4'd3,  16'hA5F0, 1'b0);
        send_item(4'd0,  16'hAAAA, 1'b1);
        send_item(4'd8,  16'h0000, 1'b1);
        send_item(4'd9,  16'h0000, 1'b1);
        send_item(4'd3,  16'h0000, 1'b1);  // undriven again

        // --- random phases, mode alternates; phase 3 runs without idling ---
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            write_mode(phase[0]);
            calm <= (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r    = $urandom_range(0, 99);
                port = PORT_W'($urandom_range(0, NUM_DRIVERS - 1));
                if (r < 2) begin
                    release_all();
                end else if (r < 16) begin
                    send_item(port, VAL_W'($urandom), 1'b1);
                end else if (r < 26) begin
                    // replay the current drive: a no-change item
                    send_item(port, drv_value[port], !drv_on[port]);
                end else begin
                    send_item(port, pick_drive_vector(), 1'b0);
                end
            end
        end

        calm <= 1'b0;
        wait_drained();
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb_wired_logic_net_resolver_unit OK");
        end else begin
            $display("tb_wired_logic_net_resolver_unit NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/wlnr_pkg.sv
rtl/wlnr_front.sv
rtl/wlnr_fifo.sv
rtl/wlnr_tree.sv
rtl/wired_logic_net_resolver_unit.sv
rtl/wlnr_checker.sv
test/net_resolution_checker.sv
test/tb_wired_logic_net_resolver_unit.sv
